FILE: rtl/core/qtue_pkg.sv
package qtue_pkg;

    // default geometry
    localparam int STATE_BITS_DEF = 12;
    localparam int MOVE_COUNT_DEF = 4;
    localparam int Q_WIDTH_DEF    = 24;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_RATE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT_RATE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_START = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_DECAY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_FLOOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANDOM_SEED   = 3'd5;

    // register reset values, rates in Q0.16, explore start and floor in Q1.16
    localparam logic [15:0] LEARN_RATE_RST    = 16'd6554;
    localparam logic [15:0] DISCOUNT_RATE_RST = 16'd62259;
    localparam logic [16:0] EXPLORE_START_RST = 17'd65536;
    localparam logic [15:0] EXPLORE_DECAY_RST = 16'd65208;
    localparam logic [16:0] EXPLORE_FLOOR_RST = 17'd655;
    localparam logic [31:0] DEFAULT_SEED      = 32'd2463534242;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // item codes
    localparam logic       ACT_CHOOSE = 1'b0;
    localparam logic       ACT_UPDATE = 1'b1;
    localparam logic [1:0] RWD_APPLE  = 2'd1;
    localparam logic [1:0] RWD_LOST   = 2'd2;

    // rewards in Q.8
    localparam int REWARD_STEP_Q  = -256;
    localparam int REWARD_APPLE_Q = 25600;
    localparam int REWARD_LOST_Q  = -25600;

    // one step of the xorshift32 generator
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

FILE: rtl/core/q_table_update_engine_unit.sv
// choose word: result goes through read, pick and output, in that order
// update word: result goes through the stages in order (read with gamma
// multiply, target, blend multiplies, round/clamp/write back); one word in flight
// the sequencer takes a new word only once the result of the last one is registered
// synchronous active-low reset loads registers, then sweeps the Q memory to zero
// one row per cycle, with o_ready low until the sweep is done
module q_table_update_engine_unit #(
    parameter int STATE_BITS = qtue_pkg::STATE_BITS_DEF,
    parameter int MOVE_COUNT = qtue_pkg::MOVE_COUNT_DEF,
    parameter int Q_WIDTH    = qtue_pkg::Q_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qtue_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [qtue_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [STATE_BITS-1:0]             i_state_index,
    input  logic [1:0]                        i_move_taken,
    input  logic [1:0]                        i_reward_kind,
    input  logic [STATE_BITS-1:0]             i_next_state_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_chosen_move,
    output logic                              o_was_random,
    output logic signed [Q_WIDTH-1:0]         o_new_q_value,
    output logic                              o_saturated
);
    import qtue_pkg::*;

    localparam int MOVE_BITS = (MOVE_COUNT > 2) ? $clog2(MOVE_COUNT) : 1;
    localparam int ROWS      = 1 << STATE_BITS;
    localparam int ROW_W     = MOVE_COUNT * Q_WIDTH;
    localparam int PF_W      = Q_WIDTH + 17;
    localparam int TGT_W     = Q_WIDTH + 2;
    localparam int PO_W      = Q_WIDTH + 18;
    localparam int PT_W      = TGT_W + 17;
    localparam int SUM_W     = PT_W + 1;
    localparam int MOD_SH    = 24;
    localparam logic [MOD_SH-1:0] MOD_RECIP =
        MOD_SH'(((64'd1 << MOD_SH) + MOVE_COUNT - 1) / MOVE_COUNT);
    localparam logic signed [SUM_W-1:0] Q_MAX =
        $signed({{(SUM_W-Q_WIDTH+1){1'b0}}, {(Q_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] Q_MIN =
        $signed({{(SUM_W-Q_WIDTH+1){1'b1}}, {(Q_WIDTH-1){1'b0}}});

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_TGT   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // control and configuration
    logic [2:0]            r_state, n_state;
    logic [STATE_BITS-1:0] r_clr_addr;
    logic [15:0]           r_learn_rate;
    logic [15:0]           r_discount_rate;
    logic [15:0]           r_explore_decay;
    logic [16:0]           r_explore_floor;
    logic [16:0]           r_eps;
    logic [31:0]           r_rand;

    // latched word
    logic                  r_action;
    logic [STATE_BITS-1:0] r_state_idx;
    logic [MOVE_BITS-1:0]  r_move;
    logic [1:0]            r_kind;

    // memory and datapath
    logic [ROW_W-1:0]          mem [ROWS];
    logic [ROW_W-1:0]          r_row_a, r_row_b;
    logic [MOVE_BITS-1:0]      r_pick;
    logic                      r_explored;
    logic signed [PF_W-1:0]    r_prod_f;
    logic signed [Q_WIDTH-1:0] r_old;
    logic [32:0]               r_eps_prod;
    logic signed [TGT_W-1:0]   r_target;
    logic signed [PO_W-1:0]    r_p_old;
    logic signed [PT_W-1:0]    r_p_tgt;

    // output word
    logic                      r_o_valid;
    logic [1:0]                r_o_move;
    logic                      r_o_random;
    logic signed [Q_WIDTH-1:0] r_o_q;
    logic                      r_o_sat;

    logic                      accept;
    logic                      out_free;
    logic [3:0]                move_wide;
    logic signed [Q_WIDTH-1:0] best_a, best_b;
    logic [MOVE_BITS-1:0]      best_a_idx;
    logic [31:0]               rand1;
    logic [39:0]               mod_prod;
    logic [15:0]               mod_r;
    logic                      explore;
    logic signed [PF_W-1:0]    fut_sh;
    logic signed [TGT_W-1:0]   reward;
    logic [16:0]               inv_alpha;
    logic signed [SUM_W-1:0]   blend_sum, blend_sh;
    logic signed [Q_WIDTH-1:0] q_new;
    logic                      q_sat;
    logic [33:0]               eps_rnd;
    logic [16:0]               eps_dec;
    logic                      mem_we;
    logic [STATE_BITS-1:0]     mem_waddr;
    logic [ROW_W-1:0]          mem_wdata;

    assign o_ready       = (r_state == S_IDLE);
    assign accept        = i_valid && o_ready;
    assign out_free      = !r_o_valid || i_ready;
    assign o_valid       = r_o_valid;
    assign o_chosen_move = r_o_move;
    assign o_was_random  = r_o_random;
    assign o_new_q_value = r_o_q;
    assign o_saturated   = r_o_sat;

    // move index folded into range
    always_comb begin
        move_wide = {2'b00, i_move_taken};
        if (move_wide >= 4'(MOVE_COUNT)) begin
            move_wide = move_wide - 4'(MOVE_COUNT);
        end
    end

    // greedy pick on current row, best value on next-state row
    always_comb begin
        best_a     = $signed(r_row_a[0 +: Q_WIDTH]);
        best_a_idx = '0;
        best_b     = $signed(r_row_b[0 +: Q_WIDTH]);
        for (int m = 1; m < MOVE_COUNT; m++) begin
            if ($signed(r_row_a[m*Q_WIDTH +: Q_WIDTH]) > best_a) begin
                best_a     = $signed(r_row_a[m*Q_WIDTH +: Q_WIDTH]);
                best_a_idx = MOVE_BITS'(m);
            end
            if ($signed(r_row_b[m*Q_WIDTH +: Q_WIDTH]) > best_b) begin
                best_b = $signed(r_row_b[m*Q_WIDTH +: Q_WIDTH]);
            end
        end
    end

    // exploration test and random move, remainder by reciprocal multiply
    assign explore  = {1'b0, r_rand[31:16]} < r_eps;
    assign rand1    = xorshift32(r_rand);
    assign mod_prod = 40'(rand1[31:16]) * 40'(MOD_RECIP);
    assign mod_r    = rand1[31:16] - 16'(mod_prod[39:24] * 16'(MOVE_COUNT));

    // target = reward + round(gamma * best)
    always_comb begin
        fut_sh = (r_prod_f + $signed(PF_W'(32768))) >>> 16;
        unique case (r_kind)
            RWD_APPLE: reward = TGT_W'(REWARD_APPLE_Q);
            RWD_LOST:  reward = TGT_W'(REWARD_LOST_Q);
            default:   reward = TGT_W'(REWARD_STEP_Q);
        endcase
    end

    assign inv_alpha = ONE_Q16 - {1'b0, r_learn_rate};

    // blend rounding and clamp
    always_comb begin
        blend_sum = SUM_W'(r_p_old) + SUM_W'(r_p_tgt) + $signed(SUM_W'(32768));
        blend_sh  = blend_sum >>> 16;
        q_sat     = 1'b0;
        if (blend_sh > Q_MAX) begin
            q_new = Q_MAX[Q_WIDTH-1:0];
            q_sat = 1'b1;
        end else if (blend_sh < Q_MIN) begin
            q_new = Q_MIN[Q_WIDTH-1:0];
            q_sat = 1'b1;
        end else begin
            q_new = blend_sh[Q_WIDTH-1:0];
        end
    end

    // epsilon decay with floor
    assign eps_rnd = {1'b0, r_eps_prod} + 34'd32768;
    assign eps_dec = eps_rnd[32:16];

    // write port: clearing sweep or row write back
    always_comb begin
        mem_we    = (r_state == S_CLEAR)
                 || (r_state == S_DONE && out_free && r_action == ACT_UPDATE);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_state_idx;
        mem_wdata = r_row_a;
        for (int m = 0; m < MOVE_COUNT; m++) begin
            if (r_move == MOVE_BITS'(m)) begin
                mem_wdata[m*Q_WIDTH +: Q_WIDTH] = q_new;
            end
        end
        if (r_state == S_CLEAR) begin
            mem_wdata = '0;
        end
    end

    // Q memory, two read ports captured on accept
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_row_a <= mem[i_state_index];
            r_row_b <= mem[i_next_state_index];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = (r_action == ACT_CHOOSE) ? S_DONE : S_TGT;
            S_TGT:   n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_learn_rate    <= LEARN_RATE_RST;
            r_discount_rate <= DISCOUNT_RATE_RST;
            r_explore_decay <= EXPLORE_DECAY_RST;
            r_explore_floor <= EXPLORE_FLOOR_RST;
            r_eps           <= EXPLORE_START_RST;
            r_rand          <= DEFAULT_SEED;
            r_o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // generator steps on choose, and once more when the choose explores
            if (accept && i_action == ACT_CHOOSE) begin
                r_rand <= xorshift32(r_rand);
            end
            if (r_state == S_READ && r_action == ACT_CHOOSE && explore) begin
                r_rand <= rand1;
            end
            // output word handshake
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
                if (r_action == ACT_UPDATE && r_kind == RWD_LOST) begin
                    r_eps <= (eps_dec < r_explore_floor) ? r_explore_floor : eps_dec;
                end
            end
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEARN_RATE:    r_learn_rate    <= i_cfg_data[15:0];
                    CFG_DISCOUNT_RATE: r_discount_rate <= i_cfg_data[15:0];
                    CFG_EXPLORE_START: r_eps           <= i_cfg_data[16:0];
                    CFG_EXPLORE_DECAY: r_explore_decay <= i_cfg_data[15:0];
                    CFG_EXPLORE_FLOOR: r_explore_floor <= i_cfg_data[16:0];
                    CFG_RANDOM_SEED: begin
                        r_rand <= (i_cfg_data == '0) ? DEFAULT_SEED : i_cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= i_action;
            r_state_idx <= i_state_index;
            r_move      <= move_wide[MOVE_BITS-1:0];
            r_kind      <= i_reward_kind;
        end
        if (r_state == S_READ) begin
            r_pick     <= explore ? mod_r[MOVE_BITS-1:0] : best_a_idx;
            r_explored <= explore;
            r_prod_f   <= $signed({1'b0, r_discount_rate}) * best_b;
            r_old      <= $signed(r_row_a[r_move*Q_WIDTH +: Q_WIDTH]);
            r_eps_prod <= 33'(r_eps) * 33'(r_explore_decay);
        end
        if (r_state == S_TGT) begin
            r_target <= fut_sh[TGT_W-1:0] + reward;
        end
        if (r_state == S_MUL) begin
            r_p_old <= $signed({1'b0, inv_alpha}) * r_old;
            r_p_tgt <= $signed({1'b0, r_learn_rate}) * r_target;
        end
        if (r_state == S_DONE && out_free) begin
            if (r_action == ACT_CHOOSE) begin
                r_o_move   <= 2'(r_pick);
                r_o_random <= r_explored;
                r_o_q      <= '0;
                r_o_sat    <= 1'b0;
            end else begin
                r_o_move   <= 2'd0;
                r_o_random <= 1'b0;
                r_o_q      <= q_new;
                r_o_sat    <= q_sat;
            end
        end
    end

endmodule

FILE: rtl/core/qtue_checker.sv
module qtue_checker #(
    parameter int Q_WIDTH = qtue_pkg::Q_WIDTH_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [1:0]                o_chosen_move,
    input logic                      o_was_random,
    input logic signed [Q_WIDTH-1:0] o_new_q_value,
    input logic                      o_saturated
);
    localparam logic signed [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_chosen_move)
            && $stable(o_was_random) && $stable(o_new_q_value) && $stable(o_saturated))
        else $error("result word changed while stalled");

    // reset starts the clearing sweep with nothing pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("block ready or valid right after reset");

    // one word in flight
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in flight");

    // choose fields and update fields never mix
    a_fields_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_chosen_move != 2'd0 || o_was_random)
            |-> o_new_q_value == '0 && !o_saturated)
        else $error("choose result carries update fields");

    // a clamped value sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_new_q_value == Q_MAX || o_new_q_value == Q_MIN)
        else $error("saturated value off the range limit");

endmodule

bind q_table_update_engine_unit qtue_checker #(
    .Q_WIDTH(Q_WIDTH)
) u_qtue_checker (.*);

FILE: tb/sv/tb_q_table_update_engine_unit.sv
`timescale 1ns / 1ps

module tb_q_table_update_engine_unit;
    import qtue_pkg::*;

    // one result word as the block presents it
    typedef struct packed {
        logic [1:0]  move;
        logic        was_random;
        logic [23:0] q_value;
        logic        sat;
    } t_q_result;

    // tracks the q store, epsilon and the random word, and checks result words in order
    class q_learn_scoreboard;
        logic signed [Q_WIDTH_DEF-1:0] q_tab [(1 << STATE_BITS_DEF) * MOVE_COUNT_DEF];
        logic [15:0] alpha;
        logic [15:0] gamma;
        logic [15:0] decay;
        logic [16:0] eps_start;
        logic [16:0] eps_floor;
        logic [16:0] eps;
        logic [31:0] seed;
        logic [31:0] rnd;
        t_q_result   expected_words [$];
        int errors;
        int shown;
        int chooses;
        int updates;
        int explored;
        int clamped;

        function new();
            foreach (q_tab[i]) q_tab[i] = '0;
            alpha     = LEARN_RATE_RST;
            gamma     = DISCOUNT_RATE_RST;
            eps_start = EXPLORE_START_RST;
            decay     = EXPLORE_DECAY_RST;
            eps_floor = EXPLORE_FLOOR_RST;
            seed      = DEFAULT_SEED;
            eps       = eps_start;
            rnd       = seed;
            errors    = 0;
            shown     = 0;
            chooses   = 0;
            updates   = 0;
            explored  = 0;
            clamped   = 0;
        endfunction

        // register write, with the side loads of epsilon and the random word
        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LEARN_RATE:    alpha = data[15:0];
                CFG_DISCOUNT_RATE: gamma = data[15:0];
                CFG_EXPLORE_START: begin
                    eps_start = data[16:0];
                    eps       = data[16:0];
                end
                CFG_EXPLORE_DECAY: decay = data[15:0];
                CFG_EXPLORE_FLOOR: eps_floor = data[16:0];
                CFG_RANDOM_SEED: begin
                    seed = data;
                    rnd  = (data == '0) ? DEFAULT_SEED : data;
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] advance_rng();
            logic [31:0] x;
            x = rnd;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            rnd = x;
            return x;
        endfunction

        function int slot_of(logic [STATE_BITS_DEF-1:0] s, logic [1:0] m);
            return int'(s) * MOVE_COUNT_DEF + int'(m);
        endfunction

        // work out the result of one accepted input word
        function void accept_word(logic act, logic [STATE_BITS_DEF-1:0] st, logic [1:0] mv,
                                  logic [1:0] kind, logic [STATE_BITS_DEF-1:0] nxt);
            t_q_result r;
            logic [31:0] w;
            logic signed [Q_WIDTH_DEF-1:0] best_q;
            longint old_v;
            longint best_v;
            longint v;
            longint rwd;
            longint tgt;
            longint blend;
            longint qmax;
            longint qmin;
            longint e;
            r = '0;
            if (act == ACT_CHOOSE) begin
                chooses++;
                w = advance_rng();
                if (w[31:16] < eps) begin
                    // exploring move from a second draw
                    w = advance_rng();
                    r.was_random = 1'b1;
                    r.move = 2'(w[31:16] % MOVE_COUNT_DEF);
                    explored++;
                end else begin
                    // greedy move, ties to the lowest move
                    best_q = q_tab[slot_of(st, 2'd0)];
                    for (int m = 1; m < MOVE_COUNT_DEF; m++) begin
                        if (q_tab[slot_of(st, 2'(m))] > best_q) begin
                            best_q = q_tab[slot_of(st, 2'(m))];
                            r.move = 2'(m);
                        end
                    end
                end
            end else begin
                updates++;
                qmax = (longint'(1) <<< (Q_WIDTH_DEF - 1)) - 1;
                qmin = -qmax - 1;
                old_v = q_tab[slot_of(st, mv)];
                best_v = q_tab[slot_of(nxt, 2'd0)];
                for (int m = 1; m < MOVE_COUNT_DEF; m++) begin
                    v = q_tab[slot_of(nxt, 2'(m))];
                    if (v > best_v) best_v = v;
                end
                case (kind)
                    RWD_APPLE: rwd = REWARD_APPLE_Q;
                    RWD_LOST:  rwd = REWARD_LOST_Q;
                    default:   rwd = REWARD_STEP_Q;
                endcase
                // bellman blend, half-up rounding on the gamma product and on the blended sum
                tgt = rwd + ((longint'(gamma) * best_v + 32768) >>> 16);
                blend = ((longint'(ONE_Q16) - longint'(alpha)) * old_v
                         + longint'(alpha) * tgt + 32768) >>> 16;
                if (blend > qmax) begin
                    blend = qmax;
                    r.sat = 1'b1;
                end else if (blend < qmin) begin
                    blend = qmin;
                    r.sat = 1'b1;
                end
                if (r.sat) clamped++;
                q_tab[slot_of(st, mv)] = blend[Q_WIDTH_DEF-1:0];
                r.q_value = blend[Q_WIDTH_DEF-1:0];
                // a lost episode decays epsilon down to the floor
                if (kind == RWD_LOST) begin
                    e = (longint'(eps) * longint'(decay) + 32768) >>> 16;
                    if (e < longint'(eps_floor)) eps = eps_floor;
                    else eps = 17'(e);
                end
            end
            expected_words.push_back(r);
        endfunction

        function void note_error(string msg);
            errors++;
            if (shown < 10) begin
                shown++;
                $display("error: %s", msg);
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result_word(logic [1:0] mv, logic was_rnd, logic [23:0] qv,
                                        logic sat);
            t_q_result exp_r;
            if (expected_words.size() == 0) begin
                note_error($sformatf("result word with nothing expected: move %0d q %0d",
                                     mv, $signed(qv)));
                return;
            end
            exp_r = expected_words.pop_front();
            if (exp_r.move !== mv || exp_r.was_random !== was_rnd ||
                exp_r.q_value !== qv || exp_r.sat !== sat) begin
                note_error($sformatf(
                    "exp move %0d rnd %0d q %0d sat %0d, got move %0d rnd %0d q %0d sat %0d",
                    exp_r.move, exp_r.was_random, $signed(exp_r.q_value), exp_r.sat,
                    mv, was_rnd, $signed(qv), sat));
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void check_drained();
            if (expected_words.size() != 0)
                note_error($sformatf("%0d result words never arrived",
                                     expected_words.size()));
        endfunction
    endclass

    localparam int SB = STATE_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 10;
    localparam int SAT_PHASE = 9;

    localparam logic [1:0] RWD_STEP = 2'd0;
    localparam logic [1:0] RWD_ODD  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAD_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAD_HI = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_action = 1'b0;
    logic [SB-1:0]          i_state_index = '0;
    logic [1:0]             i_move_taken = '0;
    logic [1:0]             i_reward_kind = '0;
    logic [SB-1:0]          i_next_state_index = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [1:0]             o_chosen_move;
    logic                   o_was_random;
    logic signed [Q_WIDTH_DEF-1:0] o_new_q_value;
    logic                   o_saturated;

    bit no_idle = 1'b0;
    bit long_hold = 1'b0;
    int settings_done = 0;

    q_learn_scoreboard q_tracker = new();

    logic [SB-1:0] state_pool [16];

    q_table_update_engine_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_state_index      (i_state_index),
        .i_move_taken       (i_move_taken),
        .i_reward_kind      (i_reward_kind),
        .i_next_state_index (i_next_state_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_chosen_move      (o_chosen_move),
        .o_was_random       (o_was_random),
        .o_new_q_value      (o_new_q_value),
        .o_saturated        (o_saturated)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            q_tracker.check_result_word(o_chosen_move, o_was_random, o_new_q_value,
                                        o_saturated);
    end

    // receiver: random stalls per word, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // offer one input word and hold it until accepted
    task automatic send_word(input logic act, input logic [SB-1:0] st, input logic [1:0] mv,
                             input logic [1:0] kind, input logic [SB-1:0] nxt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_action           <= act;
        i_state_index      <= st;
        i_move_taken       <= mv;
        i_reward_kind      <= kind;
        i_next_state_index <= nxt;
        do @(posedge i_clk); while (!o_ready);
        q_tracker.accept_word(act, st, mv, kind, nxt);
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        while (q_tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        q_tracker.apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [1:0] pick_kind();
        int k;
        k = $urandom_range(0, 19);
        if (k < 13) return RWD_STEP;
        if (k < 16) return RWD_APPLE;
        if (k < 19) return RWD_LOST;
        return RWD_ODD;
    endfunction

    // register settings per phase, extremes on chosen phases
    task automatic set_phase(input int p);
        logic [15:0] a;
        logic [15:0] g;
        logic [15:0] d;
        logic [16:0] es;
        logic [16:0] fl;
        logic [31:0] sd;
        a  = 16'($urandom);
        g  = 16'($urandom);
        d  = 16'($urandom_range(60000, 65535));
        es = 17'($urandom_range(0, 65536));
        fl = 17'($urandom_range(0, 2000));
        sd = $urandom;
        case (p)
            0: begin a = 16'd0; g = 16'hFFFF; end
            1: begin a = 16'hFFFF; g = 16'd0; end
            2: es = 17'd0;
            3: es = ONE_Q16;
            4: begin d = 16'd0; fl = 17'd0; end
            5: begin d = 16'hFFFF; fl = 17'd0; end
            6: fl = ONE_Q16;
            7: sd = 32'd0;
            8: begin sd = 32'hFFFF_FFFF; es = ONE_Q16; d = 16'($urandom); end
            SAT_PHASE: begin a = 16'hFFFF; g = 16'hFFFF; es = 17'd0; fl = 17'd0; end
            default: ;
        endcase
        // upper data bits carry junk that the block has to drop
        cfg_write(CFG_LEARN_RATE, {16'($urandom), a});
        cfg_write(CFG_DISCOUNT_RATE, {16'($urandom), g});
        cfg_write(CFG_EXPLORE_START, {15'($urandom), es});
        cfg_write(CFG_EXPLORE_DECAY, {16'($urandom), d});
        cfg_write(CFG_EXPLORE_FLOOR, {15'($urandom), fl});
        cfg_write(CFG_RANDOM_SEED, sd);
        if (p == 3) begin
            cfg_write(CFG_BAD_LO, $urandom);
            cfg_write(CFG_BAD_HI, $urandom);
        end
        settings_done++;
    endtask

    // episodes over a small state pool: choose then update, with some noise words
    task automatic run_episodes(input int count);
        int sent;
        int r;
        logic [SB-1:0] cur;
        logic [SB-1:0] nxt;
        logic [1:0] kind;
        sent = 0;
        state_pool[0] = '0;
        state_pool[1] = '1;
        for (int i = 2; i < 16; i++) state_pool[i] = SB'($urandom);
        cur = state_pool[$urandom_range(0, 15)];
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(1'($urandom), SB'($urandom), 2'($urandom), 2'($urandom),
                          SB'($urandom));
                sent++;
            end else begin
                nxt  = state_pool[$urandom_range(0, 15)];
                kind = pick_kind();
                send_word(ACT_CHOOSE, cur, 2'($urandom), 2'($urandom), SB'($urandom));
                send_word(ACT_UPDATE, cur, 2'($urandom), kind, nxt);
                cur = (kind == RWD_LOST) ? state_pool[$urandom_range(0, 15)] : nxt;
                sent += 2;
            end
        end
    endtask

    // one state's row pushed up to the positive limit, then knocked back
    task automatic run_saturation();
        logic [SB-1:0] s;
        s = SB'($urandom);
        for (int i = 0; i < 380; i++) begin
            if (i % 16 == 15)
                send_word(ACT_CHOOSE, s, 2'($urandom), 2'($urandom), SB'($urandom));
            else
                send_word(ACT_UPDATE, s, 2'($urandom), RWD_APPLE, s);
        end
        for (int i = 0; i < 20; i++)
            send_word(ACT_UPDATE, s, 2'($urandom), pick_kind(), s);
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);

        // directed words on reset settings, every choose before a lost update explores
        send_word(ACT_CHOOSE, '0, 2'd0, RWD_STEP, '0);
        send_word(ACT_CHOOSE, '1, 2'd3, RWD_ODD, '1);
        send_word(ACT_UPDATE, '1, 2'd3, RWD_APPLE, '1);
        send_word(ACT_UPDATE, '1, 2'd3, RWD_APPLE, '1);
        send_word(ACT_UPDATE, '1, 2'd0, RWD_STEP, '1);
        send_word(ACT_UPDATE, '0, 2'd0, RWD_STEP, '1);
        send_word(ACT_UPDATE, '0, 2'd2, RWD_ODD, '0);
        send_word(ACT_UPDATE, '1, 2'd1, RWD_LOST, '0);
        send_word(ACT_UPDATE, 12'hAAA, 2'd1, RWD_LOST, 12'h555);
        send_word(ACT_UPDATE, 12'h555, 2'd2, RWD_APPLE, 12'hAAA);
        send_word(ACT_UPDATE, 12'h555, 2'd1, RWD_APPLE, 12'h555);
        send_word(ACT_CHOOSE, 12'h555, 2'd1, RWD_LOST, 12'h000);
        drain();

        // greedy picks: best move, ties, negative entries
        cfg_write(CFG_EXPLORE_START, 32'd0);
        send_word(ACT_CHOOSE, '1, 2'd0, RWD_STEP, '0);
        send_word(ACT_CHOOSE, '0, 2'd0, RWD_STEP, '0);
        send_word(ACT_CHOOSE, 12'd123, 2'd0, RWD_STEP, '0);
        send_word(ACT_CHOOSE, 12'hAAA, 2'd0, RWD_STEP, '0);
        send_word(ACT_CHOOSE, 12'h555, 2'd0, RWD_STEP, '0);
        send_word(ACT_UPDATE, 12'd123, 2'd3, RWD_STEP, 12'd123);
        send_word(ACT_CHOOSE, 12'd123, 2'd0, RWD_STEP, '0);
        send_word(ACT_UPDATE, 12'd123, 2'd0, RWD_LOST, 12'd123);
        send_word(ACT_CHOOSE, 12'd123, 2'd0, RWD_STEP, '0);
        drain();

        // random phases, each under its own register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(p);
            no_idle = (p % 3 == 1);
            if (p == 5) long_hold = 1'b1;
            if (p == SAT_PHASE) run_saturation();
            else run_episodes(110);
            drain();
        end
        no_idle = 1'b0;
        repeat (20) @(posedge i_clk);

        q_tracker.check_drained();
        $display("covered %0d choose and %0d update words over %0d register settings",
                 q_tracker.chooses, q_tracker.updates, settings_done + 1);
        $display("%0d moves explored, %0d updates clamped, %0d errors",
                 q_tracker.explored, q_tracker.clamped, q_tracker.errors);
        if (q_tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/qtue_pkg.sv
rtl/core/q_table_update_engine_unit.sv
rtl/core/qtue_checker.sv
tb/sv/tb_q_table_update_engine_unit.sv
